[design/srcs_pkg.sv]
`default_nettype none

package srcs_pkg;

  // mode codes
  localparam logic FUNC_CAPTURE  = 1'b0;
  localparam logic FUNC_PLAYBACK = 1'b1;

  localparam logic [15:0] RATE_MIN  = 16'd4000;
  localparam logic [15:0] RATE_MAX  = 16'd48000;
  localparam logic [15:0] RATE_STEP = 16'd3000;
  localparam logic [15:0] HIGH_RATE = 16'd24000;

  localparam logic [8:0]  TRUNC_MULT   = 9'd21;
  localparam logic [8:0]  TRUNC_CAP_HI = 9'd239;
  localparam logic [8:0]  TRUNC_CAP_LO = 9'd119;
  localparam logic [15:0] TRUNC_LO_FLAG = 16'h8000;

  // long division: 31-bit dividend, 19-bit divisor, 20-bit quotient
  localparam int NUM_W      = 31;
  localparam int DEN_W      = 19;
  localparam int QUO_W      = 20;
  localparam int REM_W      = DEN_W + 1;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = QUO_W / DIV_BPS;

  localparam logic [NUM_W-1:0] NUM_CAP = 31'd1572864000;  // 48000 << 15

  // floor(r / 3000) for r <= 48000 as (r * 22370) >> 26
  localparam logic [14:0] N_RECIP = 15'd22370;
  localparam int          N_SHIFT = 26;
  localparam int          N_W     = 5;

  localparam int FREQ_W = 20;

  typedef struct packed {
    logic        func;
    logic [15:0] rate;
  } in_t;

  typedef struct packed {
    logic [15:0] actual_rate;
    logic [15:0] trunc_word;
    logic [15:0] int_high_word;
    logic [14:0] frac_word;
    logic [12:0] volume_word;
  } out_t;

  typedef struct packed {
    logic              func;
    logic [N_W-1:0]    n;
    logic [15:0]       trunc;
    logic [12:0]       vol;
    logic [FREQ_W-1:0] freq;
    logic [15:0]       pb_actual;
  } div_tag_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    div_tag_t         tag;
  } div_req_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    div_tag_t         tag;
  } div_rsp_t;

endpackage

`default_nettype wire

[design/sample_rate_converter_setup.sv]
// channel  dir  handshake                    beat
// in       in   in_valid_i / in_stall_o      in_t  {func, rate}
// out      out  out_valid_o / out_stall_i    out_t {actual_rate, trunc_word, int_high_word,
//                                                   frac_word, volume_word}
//
// One beat per cycle sustained while out_stall_i is low; 13 register stages: the clamp
// stage, two radix-2 long dividers (20 quotient bits, 4 per stage, 5 stages each), the
// multiply stage and the output register.
// Reset clears only the stage valid bits; no clearing pass.
// Every stage loads when empty or when the stage after it moves, so bubbles fill
// and a stalled output still lets upstream stages advance.
`default_nettype none

module sample_rate_converter_setup import srcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic     prep_valid;
  logic     prep_stall;
  div_req_t prep_req;
  logic     div1_valid;
  logic     div1_stall;
  div_rsp_t div1_rsp;
  logic     mid_valid;
  logic     mid_stall;
  div_req_t mid_req;
  logic     div2_valid;
  logic     div2_stall;
  div_rsp_t div2_rsp;

  out_t     out_d;
  out_t     out_q;
  logic     out_valid_q;

  srcs_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (prep_valid),
    .stall_i (prep_stall),
    .req_o   (prep_req)
  );

  // rate division: 48000<<15 / r for capture, r<<15 / 3000 for playback
  srcs_div u_div_freq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .stall_o (prep_stall),
    .req_i   (prep_req),
    .valid_o (div1_valid),
    .stall_i (div1_stall),
    .rsp_o   (div1_rsp)
  );

  srcs_mid u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div1_valid),
    .stall_o (div1_stall),
    .rsp_i   (div1_rsp),
    .valid_o (mid_valid),
    .stall_i (mid_stall),
    .req_o   (mid_req)
  );

  // achieved capture rate: 48000<<15 / q
  srcs_div u_div_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .stall_o (mid_stall),
    .req_i   (mid_req),
    .valid_o (div2_valid),
    .stall_i (div2_stall),
    .rsp_o   (div2_rsp)
  );

  always_comb begin
    if (div2_rsp.tag.func == FUNC_PLAYBACK) begin
      out_d.actual_rate = div2_rsp.tag.pb_actual;
    end else begin
      out_d.actual_rate = div2_rsp.quo[15:0];
    end
    out_d.trunc_word    = div2_rsp.tag.trunc;
    out_d.int_high_word = {1'b0, div2_rsp.tag.freq[FREQ_W-1:15], 10'd0};
    out_d.frac_word     = div2_rsp.tag.freq[14:0];
    out_d.volume_word   = div2_rsp.tag.vol;
  end

  assign div2_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!div2_stall) begin
      out_valid_q <= div2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!div2_stall && div2_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_words_zero_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.trunc_word == 16'd0) == (out_data_o.volume_word == 13'd0)))
    else $error("trunc and volume words disagree on mode");

  a_n_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.trunc_word[8:4] == out_data_o.volume_word[12:8]))
    else $error("n differs between trunc and volume words");

  a_rate_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.actual_rate <= RATE_MAX) &&
                     (out_data_o.actual_rate >= RATE_STEP)))
    else $error("achieved rate out of range");
`endif

endmodule

`default_nettype wire

[design/srcs_prep.sv]
`default_nettype none

module srcs_prep import srcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  in_t      data_i,
  output logic     valid_o,
  input  logic     stall_i,
  output div_req_t req_o
);

  logic [15:0]    rate_c;
  logic [30:0]    prod_c;
  logic [N_W-1:0] n_raw_c;
  logic [N_W-1:0] n_c;
  logic [8:0]     tm_c;
  logic [8:0]     cap_c;
  logic [8:0]     tmc_c;
  logic [7:0]     half_c;
  logic [15:0]    tw_c;
  logic           hi_c;
  div_req_t       req_d;
  div_req_t       req_q;
  logic           valid_q;

  always_comb begin
    rate_c = data_i.rate;
    if (rate_c > RATE_MAX) rate_c = RATE_MAX;
    if (rate_c < RATE_MIN) rate_c = RATE_MIN;

    prod_c  = 31'(rate_c) * 31'(N_RECIP);
    n_raw_c = prod_c[N_SHIFT +: N_W];
    // odd n from 9 up drops to the even one below
    n_c = (n_raw_c[0] && (n_raw_c >= 5'd9)) ? {n_raw_c[N_W-1:1], 1'b0} : n_raw_c;

    tm_c   = ((9'(n_c) * TRUNC_MULT) - 9'd1) | 9'd1;
    hi_c   = (rate_c >= HIGH_RATE);
    cap_c  = hi_c ? TRUNC_CAP_HI : TRUNC_CAP_LO;
    tmc_c  = (tm_c > cap_c) ? cap_c : tm_c;
    half_c = 8'((cap_c - tmc_c) >> 1);
    tw_c   = {half_c[6:0], 9'd0} | {7'd0, n_c, 4'd0};
    if (!hi_c) tw_c = tw_c | TRUNC_LO_FLAG;

    req_d.tag.func      = data_i.func;
    req_d.tag.n         = n_c;
    req_d.tag.freq      = '0;
    req_d.tag.pb_actual = '0;
    if (data_i.func == FUNC_PLAYBACK) begin
      req_d.num       = {rate_c, 15'd0};
      req_d.den       = DEN_W'(RATE_STEP);
      req_d.tag.trunc = '0;
      req_d.tag.vol   = '0;
    end else begin
      req_d.num       = NUM_CAP;
      req_d.den       = DEN_W'(rate_c);
      req_d.tag.trunc = tw_c;
      req_d.tag.vol   = {n_c, 8'd0};
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      req_q <= req_d;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

[design/srcs_div.sv]
`default_nettype none

module srcs_div import srcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  div_req_t req_i,
  output logic     valid_o,
  input  logic     stall_i,
  output div_rsp_t rsp_o
);

  logic             v_q   [DIV_STAGES];
  logic [REM_W-1:0] rem_q [DIV_STAGES];
  logic [QUO_W-1:0] lq_q  [DIV_STAGES];  // dividend bits shift out, quotient bits shift in
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  div_tag_t         tag_q [DIV_STAGES];
  logic             hold  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] lq_in;
    logic [DEN_W-1:0] den_in;
    div_tag_t         tag_in;
    logic [REM_W-1:0] rem_c;
    logic [QUO_W-1:0] lq_c;

    if (s == 0) begin : g_first
      // quotient fits QUO_W bits, so the top dividend bits are already below den
      assign v_in   = valid_i;
      assign rem_in = REM_W'(req_i.num[NUM_W-1:QUO_W]);
      assign lq_in  = req_i.num[QUO_W-1:0];
      assign den_in = req_i.den;
      assign tag_in = req_i.tag;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign lq_in  = lq_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    if (s == DIV_STAGES - 1) begin : g_hold_last
      assign hold[s] = v_q[s] && stall_i;
    end else begin : g_hold_mid
      assign hold[s] = v_q[s] && hold[s+1];
    end

    always_comb begin
      rem_c = rem_in;
      lq_c  = lq_in;
      for (int b = 0; b < DIV_BPS; b++) begin
        rem_c = {rem_c[REM_W-2:0], lq_c[QUO_W-1]};
        if (rem_c >= REM_W'(den_in)) begin
          rem_c = rem_c - REM_W'(den_in);
          lq_c  = {lq_c[QUO_W-2:0], 1'b1};
        end else begin
          lq_c  = {lq_c[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (!hold[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!hold[s] && v_in) begin
        rem_q[s] <= rem_c;
        lq_q[s]  <= lq_c;
        den_q[s] <= den_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign stall_o   = hold[0];
  assign valid_o   = v_q[DIV_STAGES-1];
  assign rsp_o.quo = lq_q[DIV_STAGES-1];
  assign rsp_o.tag = tag_q[DIV_STAGES-1];

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DIV_STAGES-1] |-> (rem_q[DIV_STAGES-1] < REM_W'(den_q[DIV_STAGES-1])))
    else $error("divider remainder not below divisor");

  a_stall_from_downstream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("divider stalls without a full, stalled last stage");

  a_stalled_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(rsp_o)))
    else $error("stalled divider beat changed");
`endif

endmodule

`default_nettype wire

[design/srcs_mid.sv]
`default_nettype none

module srcs_mid import srcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  div_rsp_t rsp_i,
  output logic     valid_o,
  input  logic     stall_i,
  output div_req_t req_o
);

  logic [QUO_W+N_W-1:0] freq_prod_c;
  logic [31:0]          pb_prod_c;
  div_req_t             req_d;
  div_req_t             req_q;
  logic                 valid_q;

  always_comb begin
    freq_prod_c = (QUO_W+N_W)'(rsp_i.quo) * (QUO_W+N_W)'(rsp_i.tag.n);
    pb_prod_c   = 32'(rsp_i.quo) * 32'(RATE_STEP);

    req_d               = '0;
    req_d.tag           = rsp_i.tag;
    req_d.tag.pb_actual = pb_prod_c[30:15];
    req_d.num           = NUM_CAP;
    if (rsp_i.tag.func == FUNC_PLAYBACK) begin
      req_d.tag.freq = rsp_i.quo;
      // second quotient unused here; the 3000 divisor keeps it within QUO_W bits
      req_d.den      = DEN_W'(RATE_STEP);
    end else begin
      req_d.tag.freq = freq_prod_c[FREQ_W-1:0];
      req_d.den      = rsp_i.quo[DEN_W-1:0];
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      req_q <= req_d;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire
